// File: rtl/ibtc_pkg.sv
// Package for the indirect branch target cache.
// Holds the transfer payload types, the table entry type and the operation codes.
package ibtc_pkg;

    localparam int IBTC_INDEX_BITS = 9;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] guest_address;
        logic [63:0] host_target;
    } t_ibtc_in;

    typedef struct packed {
        logic        hit;
        logic [63:0] next_host_address;
        logic        update_wanted;
    } t_ibtc_out;

    typedef struct packed {
        logic [31:0] tag;
        logic [63:0] target;
    } t_entry;

endpackage

// File: rtl/indirect_branch_target_cache.sv
// Top level of the indirect branch target cache: input stage, compare, result register.
// Depends on ibtc_pkg and ibtc_slot_store.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   t_ibtc_in  i_in
//   out      output     o_out_valid / i_out_stall t_ibtc_out o_out
//   cfg      input      i_cfg_valid / o_cfg_ready 64-bit i_cfg_data (miss stub address)
//
// One item per cycle while neither the table clear nor a stalled result holds the input;
// a lookup passes the registered table read, then the compare and the result register.
// After reset a zero-fill sweep writes all 2**INDEX_BITS slots; no item transfers during it.
// A stalled result holds the stage behind it; updates never wait on the output.
// Configuration writes are taken in every cycle.
module indirect_branch_target_cache
    import ibtc_pkg::*;
#(
    parameter int INDEX_BITS = IBTC_INDEX_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_ibtc_in    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_ibtc_out   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data
);

    logic        r_s1_valid;
    t_ibtc_in    r_s1;
    logic        r_out_valid;
    t_ibtc_out   r_out;
    logic [31:0] r_pend_addr;
    logic        r_pend_flag;
    logic [63:0] r_miss_stub;

    logic        n_accept;
    logic        n_out_free;
    logic        n_s1_fire;
    logic        n_hit;
    logic        n_wr_en;
    t_entry      n_wr_data;
    t_entry      rd_data;
    logic        tbl_busy;

    ibtc_slot_store #(
        .INDEX_BITS (INDEX_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (n_accept),
        .i_rd_addr (i_in.guest_address[INDEX_BITS-1:0]),
        .i_wr_en   (n_wr_en),
        .i_wr_addr (r_pend_addr[INDEX_BITS-1:0]),
        .i_wr_data (n_wr_data),
        .o_rd_data (rd_data),
        .o_busy    (tbl_busy)
    );

    always_comb begin
        n_out_free = !r_out_valid || !i_out_stall;
        n_s1_fire  = r_s1_valid && ((r_s1.kind == KIND_UPDATE) || n_out_free);
        o_in_stall = tbl_busy || (r_s1_valid && !n_s1_fire);
        n_accept   = i_in_valid && !o_in_stall;
        n_hit      = (rd_data.tag == r_s1.guest_address);
        n_wr_en    = n_s1_fire && (r_s1.kind == KIND_UPDATE);
        n_wr_data.tag    = r_pend_addr;
        n_wr_data.target = r_s1.host_target;
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_s1 <= i_in;
        end
        if (n_s1_fire && (r_s1.kind == KIND_LOOKUP)) begin
            r_out.hit               <= n_hit;
            r_out.next_host_address <= n_hit ? rd_data.target : r_miss_stub;
            r_out.update_wanted     <= n_hit ? r_pend_flag : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend_addr <= '0;
            r_pend_flag <= 1'b0;
            r_miss_stub <= '0;
        end else begin
            if (n_accept) begin
                r_s1_valid <= 1'b1;
            end else if (n_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (n_s1_fire && (r_s1.kind == KIND_LOOKUP)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (n_s1_fire) begin
                if (r_s1.kind == KIND_UPDATE) begin
                    r_pend_flag <= 1'b0;
                end else if (!n_hit) begin
                    r_pend_addr <= r_s1.guest_address;
                    r_pend_flag <= 1'b1;
                end
            end
            if (i_cfg_valid) begin
                r_miss_stub <= i_cfg_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTH
    a_no_transfer_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_busy |-> o_in_stall)
        else $error("input transfer during table clear");

    a_update_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_s1_fire && (r_s1.kind == KIND_UPDATE)) |=> !r_pend_flag)
        else $error("pending flag not cleared by update");

    a_miss_latches_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_s1_fire && (r_s1.kind == KIND_LOOKUP) && !n_hit)
        |=> (r_pend_flag && (r_pend_addr == $past(r_s1.guest_address))))
        else $error("miss did not latch pending address");

    a_miss_wants_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.hit) |-> o_out.update_wanted)
        else $error("miss result without update request");
`endif

endmodule

// File: rtl/ibtc_table.sv
// Direct-mapped tag/target memory with one write and one registered read port.
// Runs a zero-fill sweep after reset and forwards a same-cycle write to the read.
// Depends on ibtc_pkg.
module ibtc_slot_store
    import ibtc_pkg::*;
#(
    parameter int INDEX_BITS = IBTC_INDEX_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [INDEX_BITS-1:0] i_rd_addr,
    input  logic                  i_wr_en,
    input  logic [INDEX_BITS-1:0] i_wr_addr,
    input  t_entry                i_wr_data,
    output t_entry                o_rd_data,
    output logic                  o_busy
);

    localparam int DEPTH = 1 << INDEX_BITS;

    t_entry                r_mem [DEPTH];
    t_entry                r_rd_data;
    t_entry                r_byp_data;
    logic                  r_byp;
    logic                  r_clr_active;
    logic [INDEX_BITS-1:0] r_clr_addr;

    logic                  n_wen;
    logic [INDEX_BITS-1:0] n_waddr;
    t_entry                n_wdata;

    always_comb begin
        n_wen   = r_clr_active || i_wr_en;
        n_waddr = r_clr_active ? r_clr_addr : i_wr_addr;
        n_wdata = r_clr_active ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (n_wen) begin
            r_mem[n_waddr] <= n_wdata;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_byp_data <= n_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp        <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            if (i_rd_en) begin
                r_byp <= n_wen && (n_waddr == i_rd_addr);
            end
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == {INDEX_BITS{1'b1}}) begin
                    r_clr_active <= 1'b0;
                end
            end
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd_data;
    assign o_busy    = r_clr_active;

endmodule

// File: dv/indirect_branch_target_cache_tb.sv
// Testbench for indirect_branch_target_cache: directed and random lookup/update traffic,
// with in-order checking against a predictor of the tag and target tables.
// Depends on ibtc_pkg and the RTL of indirect_branch_target_cache.
module indirect_branch_target_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ibtc_pkg::*;

    localparam int SLOTS = 1 << IBTC_INDEX_BITS;
    localparam logic [31:0] SLOT_MASK = 32'(SLOTS - 1);
    localparam int HOT_COUNT = 24;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 175;
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_ibtc_in    in_bus = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_ibtc_out   out_bus;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_data = '0;

    logic        xfer_seen = 1'b0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          mismatch_count = 0;

    t_ibtc_in    branch_items[$];
    t_ibtc_out   lookup_answers[$];

    logic [31:0] tag_copy[SLOTS];
    logic [63:0] target_copy[SLOTS];
    logic [31:0] pend_addr;
    logic        pend_flag;
    logic [63:0] stub_value;
    logic [31:0] hot_addresses[HOT_COUNT];

    indirect_branch_target_cache uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_bus),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_bus),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $realtime, what);
        end
    endfunction

    function automatic void resolve_branch_item(input t_ibtc_in item);
        logic [IBTC_INDEX_BITS-1:0] slot;
        t_ibtc_out answer;
        if (item.kind == KIND_UPDATE) begin
            slot = pend_addr[IBTC_INDEX_BITS-1:0];
            tag_copy[slot] = pend_addr;
            target_copy[slot] = item.host_target;
            pend_flag = 1'b0;
        end else begin
            slot = item.guest_address[IBTC_INDEX_BITS-1:0];
            answer.hit = (tag_copy[slot] == item.guest_address);
            if (answer.hit) begin
                answer.next_host_address = target_copy[slot];
            end else begin
                answer.next_host_address = stub_value;
                pend_addr = item.guest_address;
                pend_flag = 1'b1;
            end
            answer.update_wanted = pend_flag;
            lookup_answers.push_back(answer);
        end
    endfunction

    function automatic logic [63:0] random64();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return {$urandom(), $urandom()};
    endfunction

    function automatic void push_lookup(input logic [31:0] addr);
        t_ibtc_in item;
        item.kind = KIND_LOOKUP;
        item.guest_address = addr;
        item.host_target = {$urandom(), $urandom()};
        branch_items.push_back(item);
    endfunction

    function automatic void push_update(input logic [63:0] target);
        t_ibtc_in item;
        item.kind = KIND_UPDATE;
        item.guest_address = $urandom();
        item.host_target = target;
        branch_items.push_back(item);
    endfunction

    // mostly dispatch sequences: lookup of a recurring branch, then a refill of the miss
    function automatic void queue_random_phase(input int count);
        int made;
        int pick;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                push_lookup(hot_addresses[$urandom_range(HOT_COUNT - 1)]);
                made++;
                if ($urandom_range(99) < 65) begin
                    push_update(random64());
                    made++;
                end
            end else if (pick < 85) begin
                push_lookup($urandom());
                made++;
            end else begin
                push_update(random64());
                made++;
            end
        end
    endfunction

    task automatic write_stub(input logic [63:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        stub_value = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (branch_items.size() != 0 || in_valid || lookup_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // driver: accept on valid and no stall, predict at the transfer
    always @(posedge i_clk) begin
        xfer_seen <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            resolve_branch_item(in_bus);
        end
    end

    always @(negedge i_clk) begin
        if (!in_valid || xfer_seen) begin
            if (rst_n && branch_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
                in_bus <= branch_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : result_monitor
        t_ibtc_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (lookup_answers.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: hit %0b next %h wanted %0b",
                    out_bus.hit, out_bus.next_host_address, out_bus.update_wanted));
            end else begin
                want = lookup_answers.pop_front();
                if (out_bus.hit !== want.hit
                        || out_bus.next_host_address !== want.next_host_address
                        || out_bus.update_wanted !== want.update_wanted) begin
                    flag_mismatch($sformatf(
                        "expected hit %0b next %h wanted %0b, got hit %0b next %h wanted %0b",
                        want.hit, want.next_host_address, want.update_wanted,
                        out_bus.hit, out_bus.next_host_address, out_bus.update_wanted));
                end
            end
        end
    end

    initial begin
        logic [63:0] stub_plan[4];
        for (int i = 0; i < SLOTS; i++) begin
            tag_copy[i] = '0;
            target_copy[i] = '0;
        end
        pend_addr = '0;
        pend_flag = 1'b0;
        stub_value = '0;
        for (int i = 0; i < HOT_COUNT / 2; i++) begin
            hot_addresses[i] = (i == 0) ? 32'h0 : $urandom();
        end
        for (int i = HOT_COUNT / 2; i < HOT_COUNT; i++) begin
            hot_addresses[i] = ($urandom() & ~SLOT_MASK)
                | (hot_addresses[i - HOT_COUNT / 2] & SLOT_MASK);
        end

        repeat (6) @(negedge i_clk);
        rst_n <= 1'b1;

        write_stub({$urandom(), $urandom()});
        push_lookup(32'h0000_0000);
        push_update({$urandom(), $urandom()});
        push_lookup(32'h0000_0000);
        push_lookup(32'hFFFF_FFFF);
        push_lookup(32'h0000_01FF);
        push_update(64'hFFFF_FFFF_FFFF_FFFF);
        push_lookup(32'h0000_01FF);
        push_lookup(32'hFFFF_FFFF);
        push_lookup(32'h0000_0000);
        push_update(64'h0);
        push_lookup(32'hFFFF_FFFF);
        push_lookup(32'h0000_01FF);
        push_lookup(32'h8000_0000);
        push_update(64'h8000_0000_0000_0001);
        push_lookup(32'h8000_0000);
        push_lookup(32'h7FFF_FFFF);
        push_update(64'h7FFF_FFFF_FFFF_FFFE);
        push_lookup(32'h7FFF_FFFF);
        push_lookup(32'hAAAA_AAAA);
        push_update(64'h5555_5555_5555_5555);
        push_lookup(32'hAAAA_AAAA);
        push_lookup(32'h5555_5555);
        push_update(64'hAAAA_AAAA_AAAA_AAAA);
        push_lookup(32'h5555_5555);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            stub_plan[0] = '1;
            stub_plan[1] = '0;
            stub_plan[2] = {$urandom(), $urandom()};
            stub_plan[3] = {$urandom(), $urandom()};
            write_stub(stub_plan[p % 4]);
            case (p % 4)
                0: begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct = 46;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct = 46;
                end
                default: begin
                    gap_pct = 20;
                    stall_pct = 20;
                end
            endcase
            queue_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (lookup_answers.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", lookup_answers.size()));
        end
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/ibtc_pkg.sv
rtl/ibtc_table.sv
rtl/indirect_branch_target_cache.sv
dv/indirect_branch_target_cache_tb.sv
